/* design/lsr_pkg.sv */
// ----------------------------------------------------------------------------
// lsr_pkg
// Shared types and constants for the lookahead spike remover.
// ----------------------------------------------------------------------------
package lsr_pkg;

  localparam int CFG_INDEX_BITS = 8;
  localparam int CFG_DATA_BITS  = 16;
  localparam int THRESH_BITS    = 16;
  localparam int COUNT_BITS     = 4;
  localparam int ENERGY_BITS    = 19;
  localparam int FRAC_BITS      = 15;
  localparam int RING_SLOTS     = 3;

  localparam logic [CFG_INDEX_BITS-1:0] REG_ENABLE        = 8'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_NOISE_FLOOR   = 8'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_REL_THRESHOLD = 8'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ABS_THRESHOLD = 8'd3;

  localparam logic [THRESH_BITS-1:0] NOISE_FLOOR_RESET   = 16'd164;
  localparam logic [THRESH_BITS-1:0] REL_THRESHOLD_RESET = 16'd4915;
  localparam logic [THRESH_BITS-1:0] ABS_THRESHOLD_RESET = 16'd655;

  localparam logic [ENERGY_BITS-1:0] ENERGY_MAX = '1;

  typedef struct packed {
    logic [THRESH_BITS-1:0] noise_floor;
    logic [THRESH_BITS-1:0] rel_threshold;
    logic [THRESH_BITS-1:0] abs_threshold;
  } lsr_thresh_t;

endpackage

/* design/lsr_lane.sv */
// ----------------------------------------------------------------------------
// lsr_lane
// Three-point spike test for one lane: noise floor gate, direction change,
// deviation against relative and absolute thresholds, corrected middle value.
// ----------------------------------------------------------------------------
module lsr_lane
  import lsr_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  logic [SAMPLE_BITS-1:0] oldest,
  input  logic [SAMPLE_BITS-1:0] middle,
  input  logic [SAMPLE_BITS-1:0] newest,
  input  lsr_thresh_t            thresh,
  output logic                   found,
  output logic                   fixed,
  output logic [SAMPLE_BITS-1:0] middle_next,
  output logic [SAMPLE_BITS-1:0] energy
);

  localparam int SUM_BITS  = SAMPLE_BITS + 1;
  localparam int PROD_BITS = SUM_BITS + THRESH_BITS;

  logic [SUM_BITS-1:0]    sum;
  logic [SUM_BITS-1:0]    twice_m;
  logic [SUM_BITS-1:0]    dev2;
  logic [PROD_BITS-1:0]   scaled_dev;
  logic [PROD_BITS-1:0]   rel_limit;
  logic [PROD_BITS-1:0]   abs_limit;
  logic [SAMPLE_BITS-1:0] average;
  logic                   quiet;

  always_comb begin
    sum        = SUM_BITS'(oldest) + SUM_BITS'(newest);
    twice_m    = {middle, 1'b0};
    dev2       = (twice_m > sum) ? (twice_m - sum) : (sum - twice_m);
    scaled_dev = PROD_BITS'(dev2) << FRAC_BITS;
    rel_limit  = PROD_BITS'(sum) * PROD_BITS'(thresh.rel_threshold);
    abs_limit  = PROD_BITS'(thresh.abs_threshold) << 1;
    average    = sum[SUM_BITS-1:1];
    quiet      = (PROD_BITS'(oldest) < PROD_BITS'(thresh.noise_floor)) &&
                 (PROD_BITS'(middle) < PROD_BITS'(thresh.noise_floor)) &&
                 (PROD_BITS'(newest) < PROD_BITS'(thresh.noise_floor));
    found      = !quiet && ((middle > oldest) != (newest > middle));
    fixed      = found && (scaled_dev > rel_limit) && (PROD_BITS'(dev2) > abs_limit);
    middle_next = fixed ? average : middle;
    energy      = fixed ? dev2[SUM_BITS-1:1] : '0;
  end

endmodule

/* design/lookahead_spike_remover_core.sv */
// ----------------------------------------------------------------------------
// lookahead_spike_remover_core
// Multi-lane three-point spike removal filter with a two-frame lookahead.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one word is one frame of LANES unsigned magnitudes.
//   m_axis: one word per input word: the despiked frame from two frames
//     back, plus lanes with a direction change, lanes corrected and the
//     summed deviation removed (saturating).
//   cfg: register writes (enable, noise floor, relative and absolute
//     thresholds), always ready; write only while the block is idle.
// An accepted word goes to the input register; the lane tests and the
// history update then feed the output register. Throughput is one word
// per cycle while m_tready is high; the lane logic (one multiplier per
// lane) sits between those two registers.
// The first three frames after reset give all-zero words. With enable low
// the frame passes straight through and the history is held.
// When the receiver stalls, the output register holds and the input
// register fills; s_tready falls once both are full.
// Reset clears the valid flags and frame counter and loads config defaults.
// ----------------------------------------------------------------------------
module lookahead_spike_remover_core
  import lsr_pkg::*;
#(
  parameter int LANES       = 8,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // band0 .. band(LANES-1), SAMPLE_BITS each, zero padded to bytes
  input  logic [((LANES*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // out0 .. out(LANES-1), spikes_found, spikes_fixed, energy_removed, zero padded
  output logic [((LANES*SAMPLE_BITS+2*COUNT_BITS+ENERGY_BITS+7)/8)*8-1:0] m_tdata,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int IN_BITS   = LANES * SAMPLE_BITS;
  localparam int IN_BYTES  = (IN_BITS + 7) / 8;
  localparam int OUT_BITS  = IN_BITS + 2 * COUNT_BITS + ENERGY_BITS;
  localparam int OUT_BYTES = (OUT_BITS + 7) / 8;
  localparam int ACC_BITS  = (SAMPLE_BITS + 4 > ENERGY_BITS) ? SAMPLE_BITS + 4
                                                              : ENERGY_BITS + 1;

  logic                   enable;
  lsr_thresh_t            thresh;

  logic                   in_valid;
  logic [IN_BITS-1:0]     in_data;
  logic                   out_valid;
  logic [OUT_BITS-1:0]    out_data;
  logic                   advance;
  logic                   fire;

  logic [SAMPLE_BITS-1:0] hist_old [LANES];
  logic [SAMPLE_BITS-1:0] hist_mid [LANES];
  logic [1:0]             frames_seen;

  logic [SAMPLE_BITS-1:0] band        [LANES];
  logic                   lane_found  [LANES];
  logic                   lane_fixed  [LANES];
  logic [SAMPLE_BITS-1:0] middle_next [LANES];
  logic [SAMPLE_BITS-1:0] lane_energy [LANES];

  logic [COUNT_BITS-1:0]  found_count;
  logic [COUNT_BITS-1:0]  fixed_count;
  logic [ACC_BITS-1:0]    energy_sum;
  logic [ENERGY_BITS-1:0] energy_sat;
  logic [IN_BITS-1:0]     lanes_out;
  logic                   warm;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || m_tready;
  assign s_tready  = !in_valid || advance;
  assign fire      = in_valid && advance;
  assign m_tvalid  = out_valid;
  assign m_tdata   = (OUT_BYTES*8)'(out_data);
  assign warm      = frames_seen < 2'(RING_SLOTS);

  genvar g;
  generate
    for (g = 0; g < LANES; g++) begin : g_lane
      assign band[g] = in_data[g*SAMPLE_BITS +: SAMPLE_BITS];

      lsr_lane #(
        .SAMPLE_BITS(SAMPLE_BITS)
      ) u_lane (
        .oldest     (hist_old[g]),
        .middle     (hist_mid[g]),
        .newest     (band[g]),
        .thresh     (thresh),
        .found      (lane_found[g]),
        .fixed      (lane_fixed[g]),
        .middle_next(middle_next[g]),
        .energy     (lane_energy[g])
      );
    end
  endgenerate

  always_comb begin
    found_count = '0;
    fixed_count = '0;
    energy_sum  = '0;
    for (int i = 0; i < LANES; i++) begin
      found_count = found_count + COUNT_BITS'(lane_found[i]);
      fixed_count = fixed_count + COUNT_BITS'(lane_fixed[i]);
      energy_sum  = energy_sum + ACC_BITS'(lane_energy[i]);
      lanes_out[i*SAMPLE_BITS +: SAMPLE_BITS] = hist_old[i];
    end
    energy_sat = (energy_sum > ACC_BITS'(ENERGY_MAX)) ? ENERGY_MAX
                                                      : ENERGY_BITS'(energy_sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enable               <= 1'b1;
      thresh.noise_floor   <= NOISE_FLOOR_RESET;
      thresh.rel_threshold <= REL_THRESHOLD_RESET;
      thresh.abs_threshold <= ABS_THRESHOLD_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ENABLE:        enable               <= cfg_data[0];
        REG_NOISE_FLOOR:   thresh.noise_floor   <= cfg_data;
        REG_REL_THRESHOLD: thresh.rel_threshold <= cfg_data;
        REG_ABS_THRESHOLD: thresh.abs_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid    <= 1'b0;
      out_valid   <= 1'b0;
      frames_seen <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
        in_data  <= s_tdata[IN_BITS-1:0];
      end else if (fire) begin
        in_valid <= 1'b0;
      end

      if (fire) begin
        out_valid <= 1'b1;
        if (!enable) begin
          out_data <= {(2*COUNT_BITS + ENERGY_BITS)'(0), in_data};
        end else if (warm) begin
          out_data    <= '0;
          frames_seen <= frames_seen + 2'd1;
          for (int i = 0; i < LANES; i++) begin
            hist_old[i] <= hist_mid[i];
            hist_mid[i] <= band[i];
          end
        end else begin
          out_data <= {energy_sat, fixed_count, found_count, lanes_out};
          for (int i = 0; i < LANES; i++) begin
            hist_old[i] <= middle_next[i];
            hist_mid[i] <= band[i];
          end
        end
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
